>>> rtl/windowed_sine_burst_generator_defines.svh
// Assertion macros shared by the burst generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef WINDOWED_SINE_BURST_GENERATOR_DEFINES_SVH
`define WINDOWED_SINE_BURST_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WSBG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WSBG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/wsbg_pkg.sv
// Shared constants and types for the windowed sine burst generator.
// No dependencies; imported by the top level.
package wsbg_pkg;

   localparam int STEP_W     = 32;   // timestep and start register width
   localparam int LEN_W      = 24;   // ramp and hold length register width
   localparam int CSR_DATA_W = 32;   // widest configuration register
   localparam int CSR_ADDR_W = 3;
   localparam int SINE_W     = 15;   // magnitude bits of a quarter-wave entry

   localparam int PHASE_BITS_DEF       = 32;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF      = 24;

   // Pi/2 in Q30, used when the quarter-wave table is built.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_STEP = 3'd0,
      CSR_RAMP_UP    = 3'd1,
      CSR_STEADY     = 3'd2,
      CSR_RAMP_DOWN  = 3'd3,
      CSR_AMPLITUDE  = 3'd4,
      CSR_PHASE_STEP = 3'd5
   } csr_reg_type;

   // Sideband that travels with an item through the divider stages.
   typedef struct packed {
      logic              active;
      logic              neg;
      logic [SINE_W-1:0] sine_mag;
   } side_type;

endpackage

>>> rtl/windowed_sine_burst_generator.sv
// Trapezoid-windowed sine burst generator, fully pipelined.
// Depends on wsbg_pkg and windowed_sine_burst_generator_defines.svh.
//
// Usage:
//   req_* carries one timestep number per transfer (valid/ready). rsp_* returns one
//   sample per request, in order: rsp_sample_value (signed Q1.23 at the default
//   width) and rsp_active, which is high when the step lies inside the burst.
//   csr_* writes the six burst registers; a write takes effect at the clock edge
//   at which csr_write_en is high. Write only while no request is in flight.
//   A new request is taken every cycle unless a response waits with rsp_ready low.
//   The envelope divider retires one quotient bit per stage; the other stages handle
//   the offset, segment decode, phase multiply, quarter-wave lookup, sine multiply
//   and rounding. All pipeline stages advance together. While a response waits and
//   rsp_ready is low, the whole pipeline holds and req_ready is low; nothing is
//   dropped. Synchronous reset clears the registers to zero and empties the
//   pipeline.
module windowed_sine_burst_generator #(
   parameter int PHASE_BITS       = wsbg_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = wsbg_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = wsbg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wsbg_pkg::STEP_W-1:0]       req_step,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample_value,
   output logic                              rsp_active,
   input  logic                              csr_write_en,
   input  logic [wsbg_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [wsbg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wsbg_pkg::*;

   `include "windowed_sine_burst_generator_defines.svh"

   localparam int SB       = SAMPLE_BITS;
   localparam int PB       = PHASE_BITS;
   localparam int DUR_W    = LEN_W + 2;
   localparam int NUM_W    = SB + LEN_W;
   localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int FRAC_W   = PB - 2;
   localparam int SCALED_W = FRAC_W + IDX_W;
   localparam int PROD_W   = SB + SINE_W;
   localparam int RND_W    = PROD_W + 1 - SINE_W;

   localparam logic [IDX_W-1:0]  DEPTH_IDX  = IDX_W'(SINE_TABLE_DEPTH);
   localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (SINE_W - 1);
   localparam logic [SB-1:0]     Q_MAX      = SB'(1) << (SB - 1);
   localparam longint unsigned   TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // One quarter-wave entry: round(32767 * sin(pi/2 * i / depth)) via a Q30 Taylor series.
   function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      logic [63:0]     usum;
      logic [63:0]     scaled;
      x    = (HALF_PI_Q30 * i) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      usum   = 64'(sum);
      scaled = (usum * 64'd32767 + 64'd536870912) >> 30;
      if (scaled > 64'd32767) begin
         scaled = 64'd32767;
      end
      return SINE_W'(scaled);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         rom[i] = sine_entry(64'(i));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // ---------------------------------------------------------------- registers
   logic [STEP_W-1:0] start_step_ff;
   logic [LEN_W-1:0]  ramp_up_ff;
   logic [LEN_W-1:0]  steady_ff;
   logic [LEN_W-1:0]  ramp_down_ff;
   logic [SB-1:0]     amplitude_ff;
   logic [PB-1:0]     phase_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_step_ff <= '0;
         ramp_up_ff    <= '0;
         steady_ff     <= '0;
         ramp_down_ff  <= '0;
         amplitude_ff  <= '0;
         phase_step_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_STEP: begin start_step_ff <= csr_wdata; end
            CSR_RAMP_UP:    begin ramp_up_ff    <= csr_wdata[LEN_W-1:0]; end
            CSR_STEADY:     begin steady_ff     <= csr_wdata[LEN_W-1:0]; end
            CSR_RAMP_DOWN:  begin ramp_down_ff  <= csr_wdata[LEN_W-1:0]; end
            CSR_AMPLITUDE:  begin amplitude_ff  <= csr_wdata[SB-1:0]; end
            CSR_PHASE_STEP: begin phase_step_ff <= csr_wdata[PB-1:0]; end
            default: begin end
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline
   logic pipe_en;
   logic out_vld_ff;

   assign pipe_en   = !out_vld_ff || rsp_ready;
   assign req_ready = pipe_en;

   // Stage A: input register.
   logic              a_vld_ff;
   logic [STEP_W-1:0] a_step_ff;

   // Stage B: offset from the burst start.
   logic              b_vld_ff;
   logic              b_before_ff;
   logic [STEP_W-1:0] b_k_ff;
   logic [STEP_W:0]   b_diff_in;

   assign b_diff_in = {1'b0, a_step_ff} - {1'b0, start_step_ff};

   // Stage C: segment decode and phase.
   logic             c_vld_ff;
   logic             c_active_ff;
   logic             c_zero_ff;
   logic [LEN_W-1:0] c_pos_ff;
   logic [LEN_W-1:0] c_d_ff;
   logic [PB-1:0]    c_phase_ff;

   logic             c_active_in;
   logic             c_zero_in;
   logic [LEN_W-1:0] c_pos_in;
   logic [LEN_W-1:0] c_d_in;
   logic [PB-1:0]    c_phase_in;
   logic [DUR_W-1:0] dur;
   logic [DUR_W-1:0] up_hold;
   logic [DUR_W-1:0] down_pos;
   logic             outside;
   logic             in_up;
   logic             in_hold;

   assign dur      = DUR_W'(ramp_up_ff) + DUR_W'(steady_ff) + DUR_W'(ramp_down_ff);
   assign up_hold  = DUR_W'(ramp_up_ff) + DUR_W'(steady_ff);
   assign down_pos = dur - DUR_W'(1) - b_k_ff[DUR_W-1:0];
   assign outside  = b_before_ff || (b_k_ff >= STEP_W'(dur));
   assign in_up    = b_k_ff < STEP_W'(ramp_up_ff);
   assign in_hold  = b_k_ff < STEP_W'(up_hold);

   // The hold section runs through the divider as amplitude * 1 / 1; a ramp of
   // length one or less, and any step outside the burst, runs with zero magnitude.
   always_comb begin
      c_active_in = 1'b1;
      c_zero_in   = 1'b0;
      c_pos_in    = LEN_W'(1);
      c_d_in      = LEN_W'(1);
      if (outside) begin
         c_active_in = 1'b0;
         c_zero_in   = 1'b1;
      end else if (in_up) begin
         c_pos_in = b_k_ff[LEN_W-1:0];
         if (ramp_up_ff[LEN_W-1:1] == '0) begin
            c_zero_in = 1'b1;
         end else begin
            c_d_in = ramp_up_ff - LEN_W'(1);
         end
      end else if (!in_hold) begin
         c_pos_in = down_pos[LEN_W-1:0];
         if (ramp_down_ff[LEN_W-1:1] == '0) begin
            c_zero_in = 1'b1;
         end else begin
            c_d_in = ramp_down_ff - LEN_W'(1);
         end
      end
   end

   assign c_phase_in = PB'(phase_step_ff * b_k_ff[PB-1:0]);

   // Stage D: envelope numerator and table address.
   logic             d_vld_ff;
   logic             d_active_ff;
   logic             d_neg_ff;
   logic [NUM_W-1:0] d_num_ff;
   logic [LEN_W-1:0] d_d_ff;
   logic [IDX_W-1:0] d_addr_ff;

   logic [SB-1:0]       amp_mag;
   logic [SB-1:0]       mag_eff;
   logic [NUM_W-1:0]    d_num_in;
   logic [1:0]          quad;
   logic [SCALED_W-1:0] frac_scaled;
   logic [IDX_W-1:0]    table_idx;
   logic [IDX_W-1:0]    d_addr_in;

   assign amp_mag     = amplitude_ff[SB-1] ? (~amplitude_ff + 1'b1) : amplitude_ff;
   assign mag_eff     = c_zero_ff ? '0 : amp_mag;
   assign d_num_in    = NUM_W'(mag_eff) * NUM_W'(c_pos_ff);
   assign quad        = c_phase_ff[PB-1:PB-2];
   assign frac_scaled = SCALED_W'(c_phase_ff[FRAC_W-1:0]) * SCALED_W'(SINE_TABLE_DEPTH);
   assign table_idx   = frac_scaled[FRAC_W +: IDX_W];
   assign d_addr_in   = quad[0] ? (DEPTH_IDX - table_idx) : table_idx;

   // Divider stage 0 (stage E) loads the rounded numerator and reads the table.
   // Stage i retires quotient bit SB-i; the quotient builds up in div_low_ff.
   logic             div_vld_ff  [0:SB];
   logic [LEN_W-1:0] div_rem_ff  [0:SB];
   logic [SB-1:0]    div_low_ff  [0:SB];
   logic [LEN_W-1:0] div_d_ff    [0:SB];
   side_type         div_side_ff [0:SB];

   logic [NUM_W-1:0] e_num_in;
   side_type         e_side_in;

   assign e_num_in           = d_num_ff + NUM_W'(d_d_ff >> 1);
   assign e_side_in.active   = d_active_ff;
   assign e_side_in.neg      = d_neg_ff;
   assign e_side_in.sine_mag = SINE_ROM[d_addr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         c_vld_ff      <= 1'b0;
         d_vld_ff      <= 1'b0;
         div_vld_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         a_vld_ff      <= req_valid;
         b_vld_ff      <= a_vld_ff;
         c_vld_ff      <= b_vld_ff;
         d_vld_ff      <= c_vld_ff;
         div_vld_ff[0] <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_step_ff      <= req_step;
         b_before_ff    <= b_diff_in[STEP_W];
         b_k_ff         <= b_diff_in[STEP_W-1:0];
         c_active_ff    <= c_active_in;
         c_zero_ff      <= c_zero_in;
         c_pos_ff       <= c_pos_in;
         c_d_ff         <= c_d_in;
         c_phase_ff     <= c_phase_in;
         d_active_ff    <= c_active_ff;
         d_neg_ff       <= amplitude_ff[SB-1] ^ quad[1];
         d_num_ff       <= d_num_in;
         d_d_ff         <= c_d_ff;
         d_addr_ff      <= d_addr_in;
         div_rem_ff[0]  <= e_num_in[NUM_W-1:SB];
         div_low_ff[0]  <= e_num_in[SB-1:0];
         div_d_ff[0]    <= d_d_ff;
         div_side_ff[0] <= e_side_in;
      end
   end

   for (genvar i = 1; i <= SB; i++) begin : g_div
      logic [LEN_W:0]   trial;
      logic [LEN_W:0]   trial_sub;
      logic             q_bit;
      logic [LEN_W-1:0] rem_in;
      logic [SB-1:0]    low_in;

      assign trial     = {div_rem_ff[i-1], div_low_ff[i-1][SB-1]};
      assign trial_sub = trial - {1'b0, div_d_ff[i-1]};
      assign q_bit     = trial >= {1'b0, div_d_ff[i-1]};
      assign rem_in    = q_bit ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
      assign low_in    = {div_low_ff[i-1][SB-2:0], q_bit};

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[i] <= 1'b0;
         end else if (pipe_en) begin
            div_vld_ff[i] <= div_vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            div_rem_ff[i]  <= rem_in;
            div_low_ff[i]  <= low_in;
            div_d_ff[i]    <= div_d_ff[i-1];
            div_side_ff[i] <= div_side_ff[i-1];
         end
      end
   end

   // Stage M: envelope magnitude times sine magnitude.
   logic              m_vld_ff;
   logic              m_active_ff;
   logic              m_neg_ff;
   logic [PROD_W-1:0] m_p_ff;
   logic [PROD_W-1:0] m_p_in;

   assign m_p_in = PROD_W'(div_low_ff[SB]) * PROD_W'(div_side_ff[SB].sine_mag);

   // Output stage: round half away from zero, then apply the sign.
   logic             out_active_ff;
   logic [SB-1:0]    out_sample_ff;
   logic [PROD_W:0]  rnd_sum;
   logic [RND_W-1:0] rnd_mag;
   logic [RND_W-1:0] rnd_signed;

   assign rnd_sum    = (PROD_W + 1)'(m_p_ff) + ROUND_HALF;
   assign rnd_mag    = rnd_sum[PROD_W:SINE_W];
   assign rnd_signed = m_neg_ff ? (RND_W'(0) - rnd_mag) : rnd_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         m_vld_ff   <= div_vld_ff[SB];
         out_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_active_ff   <= div_side_ff[SB].active;
         m_neg_ff      <= div_side_ff[SB].neg;
         m_p_ff        <= m_p_in;
         out_active_ff <= m_active_ff;
         out_sample_ff <= rnd_signed[SB-1:0];
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_active       = out_active_ff;
   assign rsp_sample_value = out_sample_ff;

   // ---------------------------------------------------------------- checks
   `WSBG_ASSERT_IMPL(a_outside_zero, clock, reset, rsp_valid && !rsp_active,
      rsp_sample_value == '0, "sample outside the burst is not zero")
   `WSBG_ASSERT_IMPL(a_div_rem_bound, clock, reset, div_vld_ff[SB],
      div_rem_ff[SB] < div_d_ff[SB], "divider remainder not below divisor")
   `WSBG_ASSERT_IMPL(a_div_quot_bound, clock, reset, div_vld_ff[SB],
      div_low_ff[SB] <= Q_MAX, "envelope quotient exceeds the amplitude range")
   `WSBG_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready && m_vld_ff,
      $stable(m_p_ff) && m_vld_ff, "pipeline moved while the response was stalled")

endmodule

>>> tb/sv/wsbg_checker.sv
// Scoreboard for the windowed sine burst generator: keeps its own copy of the six burst
// registers and the quarter-wave sine table, predicts every response and compares in order.
// Depends on wsbg_pkg; instantiated beside the block by tb_windowed_sine_burst_generator.
module wsbg_checker (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   input  logic                                          req_ready,
   input  logic [wsbg_pkg::STEP_W-1:0]                   req_step,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   input  logic signed [wsbg_pkg::SAMPLE_BITS_DEF-1:0]   rsp_sample_value,
   input  logic                                          rsp_active,
   input  logic                                          csr_write_en,
   input  logic [wsbg_pkg::CSR_ADDR_W-1:0]               csr_index,
   input  logic [wsbg_pkg::CSR_DATA_W-1:0]               csr_wdata,
   output int                                            mismatch_count,
   output int                                            expected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W = wsbg_pkg::SAMPLE_BITS_DEF;
   localparam int PHASE_W  = wsbg_pkg::PHASE_BITS_DEF;
   localparam int DEPTH    = wsbg_pkg::SINE_TABLE_DEPTH_DEF;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [wsbg_pkg::STEP_W-1:0] step;
      logic signed [SAMPLE_W-1:0]  sample_value;
      logic                        active;
   } burst_sample_type;

   burst_sample_type sample_q[$];
   int               quarter_sine[0:DEPTH];

   logic [31:0]                cfg_start;
   logic [23:0]                cfg_up;
   logic [23:0]                cfg_steady;
   logic [23:0]                cfg_down;
   logic signed [SAMPLE_W-1:0] cfg_amp;
   logic [31:0]                cfg_phase_step;

   // Quarter-wave table in Q1.15, built from a Taylor series evaluated in Q30.
   initial begin : build_sine_table
      longint unsigned x, x2, term, scaled;
      longint          sum;
      for (int i = 0; i <= DEPTH; i++) begin
         x = (QUARTER_TURN_Q30 * 64'(i)) / 64'(DEPTH);
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
               sum = sum - longint'(term);
            else
               sum = sum + longint'(term);
         end
         if (sum < 0)
            sum = 0;
         scaled = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (scaled > 64'd32767)
            scaled = 64'd32767;
         quarter_sine[i] = int'(scaled);
      end
   end

   // Linear ramp value amp * pos / (len - 1), rounded half away from zero.
   function automatic longint ramp_env(input longint amp, input longint unsigned pos,
                                       input longint unsigned len);
      longint unsigned d, mag, q;
      if (len <= 1)
         return 0;
      d = len - 1;
      mag = (amp < 0) ? $unsigned(-amp) : $unsigned(amp);
      q = (mag * pos + d / 2) / d;
      return (amp < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic burst_sample_type predict_sample(input logic [31:0] s);
      burst_sample_type    r;
      longint unsigned     dur, k, frac, idx, magn;
      longint              env, sn, prod, res;
      logic [PHASE_W-1:0]  phase;
      logic [1:0]          quad;
      r.step = s;
      r.sample_value = '0;
      r.active = 1'b0;
      dur = 64'(cfg_up) + 64'(cfg_steady) + 64'(cfg_down);
      // No wraparound: a step before the start is simply outside the burst.
      if (s < cfg_start)
         return r;
      k = 64'(s - cfg_start);
      if (k >= dur)
         return r;
      if (k < 64'(cfg_up))
         env = ramp_env(longint'(cfg_amp), k, 64'(cfg_up));
      else if (k < 64'(cfg_up) + 64'(cfg_steady))
         env = longint'(cfg_amp);
      else
         env = ramp_env(longint'(cfg_amp), dur - 1 - k, 64'(cfg_down));
      phase = cfg_phase_step[PHASE_W-1:0] * k[PHASE_W-1:0];
      quad = phase[PHASE_W-1 -: 2];
      frac = 64'(phase[PHASE_W-3:0]);
      idx = (frac * 64'(DEPTH)) >> (PHASE_W - 2);
      case (quad)
         2'd0: sn = longint'(quarter_sine[idx]);
         2'd1: sn = longint'(quarter_sine[DEPTH - idx]);
         2'd2: sn = -longint'(quarter_sine[idx]);
         default: sn = -longint'(quarter_sine[DEPTH - idx]);
      endcase
      prod = env * sn;
      magn = (prod < 0) ? $unsigned(-prod) : $unsigned(prod);
      magn = (magn + (64'd1 << 14)) >> 15;
      res = (prod < 0) ? -longint'(magn) : longint'(magn);
      r.sample_value = res[SAMPLE_W-1:0];
      r.active = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      burst_sample_type want;
      if (reset) begin
         sample_q.delete();
         cfg_start <= '0;
         cfg_up <= '0;
         cfg_steady <= '0;
         cfg_down <= '0;
         cfg_amp <= '0;
         cfg_phase_step <= '0;
         expected_count <= 0;
      end else begin
         if (req_valid && req_ready)
            sample_q.push_back(predict_sample(req_step));
         if (rsp_valid && rsp_ready) begin
            if (sample_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%t: response with nothing expected: value %0d active %0b",
                           $realtime, rsp_sample_value, rsp_active);
            end else begin
               want = sample_q.pop_front();
               if (rsp_sample_value !== want.sample_value || rsp_active !== want.active) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%t: step 0x%08h expected %0d active %0b, got %0d active %0b",
                              $realtime, want.step, want.sample_value, want.active,
                              rsp_sample_value, rsp_active);
               end
            end
         end
         // The registers take a write at this edge; items accepted at the same edge
         // were predicted with the old settings above.
         if (csr_write_en) begin
            case (csr_index)
               wsbg_pkg::CSR_START_STEP: cfg_start <= csr_wdata[31:0];
               wsbg_pkg::CSR_RAMP_UP:    cfg_up <= csr_wdata[23:0];
               wsbg_pkg::CSR_STEADY:     cfg_steady <= csr_wdata[23:0];
               wsbg_pkg::CSR_RAMP_DOWN:  cfg_down <= csr_wdata[23:0];
               wsbg_pkg::CSR_AMPLITUDE:  cfg_amp <= csr_wdata[SAMPLE_W-1:0];
               wsbg_pkg::CSR_PHASE_STEP: cfg_phase_step <= csr_wdata[31:0];
               default: ;
            endcase
         end
         expected_count <= sample_q.size();
      end
   end

endmodule

>>> tb/sv/tb_windowed_sine_burst_generator.sv
// Top of the burst generator testbench: clock, reset, register programming, step
// stimulus in random bursts and a stalling response side. Depends on wsbg_pkg, the
// block windowed_sine_burst_generator and the scoreboard module wsbg_checker.
module tb_windowed_sine_burst_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W      = wsbg_pkg::SAMPLE_BITS_DEF;
   localparam int LONG_HOLD_OFF = 150;   // well beyond the pipeline depth
   localparam int DRAIN_CYCLES  = 40;

   logic                                    clock;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic [wsbg_pkg::STEP_W-1:0]             req_step = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]              rsp_sample_value;
   logic                                    rsp_active;
   logic                                    csr_write_en = 1'b0;
   logic [wsbg_pkg::CSR_ADDR_W-1:0]         csr_index = '0;
   logic [wsbg_pkg::CSR_DATA_W-1:0]         csr_wdata = '0;

   int mismatch_count;
   int expected_count;
   bit hold_off_req = 1'b0;
   int burst_left = 0;

   windowed_sine_burst_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_step         (req_step),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .rsp_active       (rsp_active),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   wsbg_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_step         (req_step),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .rsp_active       (rsp_active),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .expected_count   (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_windowed_sine_burst_generator: FAIL");
      $finish;
   end

   // Response side: random stall patterns in segments, plus one long hold-off on request.
   initial begin : receiver
      int mode, seg_left, hold_left;
      bit hold_off_done, ready_next;
      mode = 0;
      seg_left = 0;
      hold_left = 0;
      hold_off_done = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            hold_left = LONG_HOLD_OFF;
            hold_off_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode = $urandom_range(0, 3);
               seg_left = $urandom_range(8, 80);
            end
            seg_left--;
            case (mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_ready <= ready_next;
         @(posedge clock);
      end
   end

   // Offers one step and returns at the edge where it is accepted. Valid stays high
   // within a burst; before a new burst it may drop for a random gap.
   task automatic offer_step(input logic [31:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_step <= s;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Stops offering and waits until every outstanding response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_count != 0)
         @(posedge clock);
   endtask

   // Writes all six registers on consecutive edges. The length and amplitude writes
   // carry junk above the register width, which the block must ignore.
   task automatic program_burst(input logic [31:0] st, input logic [23:0] up,
                                input logic [23:0] hold, input logic [23:0] down,
                                input logic [23:0] amp, input logic [31:0] ps,
                                input logic [7:0] junk);
      csr_write_en <= 1'b1;
      csr_index <= wsbg_pkg::CSR_START_STEP;
      csr_wdata <= st;
      @(posedge clock);
      csr_index <= wsbg_pkg::CSR_RAMP_UP;
      csr_wdata <= {junk, up};
      @(posedge clock);
      csr_index <= wsbg_pkg::CSR_STEADY;
      csr_wdata <= {junk, hold};
      @(posedge clock);
      csr_index <= wsbg_pkg::CSR_RAMP_DOWN;
      csr_wdata <= {junk, down};
      @(posedge clock);
      csr_index <= wsbg_pkg::CSR_AMPLITUDE;
      csr_wdata <= {junk, amp};
      @(posedge clock);
      csr_index <= wsbg_pkg::CSR_PHASE_STEP;
      csr_wdata <= ps;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [23:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 24'd0;
         1: return 24'd1;
         2: return 24'hFF_FFFF;
         3: return 24'($urandom);
         default: return 24'($urandom_range(2, 40));
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0]     st, ps, s, junk;
      logic [23:0]     up, hold, down, amp;
      longint unsigned dur;
      int              r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers straight out of reset describe an empty burst.
      offer_step(32'h0000_0000);
      offer_step(32'hFFFF_FFFF);
      offer_step(32'h5A5A_A5A5);
      settle();

      // Short full-scale burst walked step by step, with neighbors on both sides.
      program_burst(32'd100, 24'd4, 24'd3, 24'd5, 24'h7F_FFFF, 32'h1000_0000, 8'h00);
      offer_step(32'd99);
      for (s = 32'd100; s <= 32'd112; s++)
         offer_step(s);
      offer_step(32'h0000_0000);
      offer_step(32'hFFFF_FFFF);
      settle();

      // Single-step ramps, most negative amplitude, burst at the top of the step range.
      program_burst(32'hFFFF_FFFC, 24'd1, 24'd2, 24'd1, 24'h80_0000, 32'h4000_0000, 8'h00);
      for (int i = 0; i < 5; i++)
         offer_step(32'hFFFF_FFFB + i);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 3))
            0: st = 32'h0000_0000;
            1: st = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: st = $urandom;
         endcase
         up = pick_length();
         hold = pick_length();
         down = pick_length();
         if ($urandom_range(0, 3) == 0)
            amp = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
         else
            amp = 24'($urandom);
         case ($urandom_range(0, 7))
            0: ps = 32'h0000_0000;
            1: ps = 32'hFFFF_FFFF;
            2: ps = 32'h4000_0000;
            default: ps = $urandom;
         endcase
         if (ph == 0) begin
            up = 24'hFF_FFFF;
            hold = 24'hFF_FFFF;
            down = 24'hFF_FFFF;
            amp = 24'h7F_FFFF;
         end else if (ph == 1) begin
            amp = 24'h80_0000;
            ps = 32'hFFFF_FFFF;
         end
         junk = $urandom;
         program_burst(st, up, hold, down, amp, ps, junk[7:0]);
         dur = 64'(up) + 64'(hold) + 64'(down);

         // Fill the pipeline against a stalled response side so the input stalls too.
         if (ph == 3) begin
            hold_off_req = 1'b1;
            burst_left = 1000;
         end

         for (int n = 0; n < 60; n++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
               s = $urandom;
            else if (r == 1)
               s = st - $urandom_range(1, 4);
            else if (r == 2)
               s = st + 32'(dur) + $urandom_range(0, 3);
            else if (dur == 0)
               s = st;
            else
               s = st + 32'(64'($urandom) % dur);
            offer_step(s);
            if (ph == 5 && n == 30)
               settle();
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_count == 0)
         $display("tb_windowed_sine_burst_generator: PASS");
      else
         $display("tb_windowed_sine_burst_generator: FAIL");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wsbg_pkg.sv
rtl/windowed_sine_burst_generator.sv
tb/sv/wsbg_checker.sv
tb/sv/tb_windowed_sine_burst_generator.sv
